/* hw/rtl/ppd_pkg.sv */
package ppd_pkg;

   localparam int OPEN_DEPTH_DEF  = 16;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int EPS_BITS        = 24;
   localparam int FMT_BITS        = 3;
   localparam int PROM_BITS       = 33;
   localparam int SAT_BITS        = 34;

   // configuration register indexes
   localparam logic CSR_EPS = 1'b0;
   localparam logic CSR_FMT = 1'b1;

   // saturation formats
   localparam logic [FMT_BITS-1:0] FMT_INT8   = 3'd0;
   localparam logic [FMT_BITS-1:0] FMT_UINT8  = 3'd1;
   localparam logic [FMT_BITS-1:0] FMT_INT16  = 3'd2;
   localparam logic [FMT_BITS-1:0] FMT_UINT16 = 3'd3;
   localparam logic [FMT_BITS-1:0] FMT_INT32  = 3'd4;
   localparam logic [FMT_BITS-1:0] FMT_UINT32 = 3'd5;

   // direction codes
   localparam logic [1:0] DIR_FLAT = 2'd0;
   localparam logic [1:0] DIR_RISE = 2'd1;
   localparam logic [1:0] DIR_FALL = 2'd2;

   function automatic logic [PROM_BITS-1:0] saturate(input logic signed [SAT_BITS-1:0] v,
                                                     input logic [FMT_BITS-1:0] fmt);
      logic signed [SAT_BITS-1:0] lo;
      logic signed [SAT_BITS-1:0] hi;
      logic signed [SAT_BITS-1:0] r;
      case (fmt)
         FMT_INT8:   begin lo = -34'sd128;        hi = 34'sd127;        end
         FMT_UINT8:  begin lo = 34'sd0;           hi = 34'sd255;        end
         FMT_INT16:  begin lo = -34'sd32768;      hi = 34'sd32767;      end
         FMT_UINT16: begin lo = 34'sd0;           hi = 34'sd65535;      end
         FMT_UINT32: begin lo = 34'sd0;           hi = 34'sd4294967295; end
         default:    begin lo = -34'sd2147483648; hi = 34'sd2147483647; end
      endcase
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      else r = v;
      return r[PROM_BITS-1:0];
   endfunction

endpackage

/* hw/rtl/ppd_ram.sv */
module ppd_ram
   import ppd_pkg::*;
#(
   parameter int WIDTH = 3 * SAMPLE_BITS_DEF,
   parameter int DEPTH = OPEN_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ppd_alu.sv */
module ppd_alu
   import ppd_pkg::*;
#(
   parameter int WIDTH = SAMPLE_BITS_DEF + 2
) (
   input  logic signed [WIDTH-1:0] a,
   input  logic signed [WIDTH-1:0] b,
   input  logic                    sub,
   output logic signed [WIDTH-1:0] res,
   output logic                    neg,
   output logic                    zero
);

   assign res  = sub ? (a - b) : (a + b);
   assign neg  = res[WIDTH-1];
   assign zero = (res == '0);

endmodule

/* hw/rtl/peak_prominence_detector_core.sv */
// Streaming peak and trough prominence detector. Each accepted sample is
// classed against the previous one as rise, fall or flat (deadband +/- eps);
// a fall then rise marks a trough at the previous sample, a rise then fall a
// peak. Open extrema sit on two stacks of OPEN_DEPTH entries; a new extremum
// closes every open peak strictly below it or open trough strictly above it,
// and each close gives one result item with the saturated prominence, the
// causing sample and tlast on the final item of that sample. The sequencer's
// arithmetic runs through one shared adder/subtractor (the run-extreme updates
// and the saturation sit beside it), so req_tready is high only while the
// sequencer is idle. A sample without a turn passes S_DX, S_RISE, S_FALL,
// S_DEC and S_FIN before the next one can be taken; a turn adds S_CMP, then
// S_PL, S_MRG, S_PR, S_MIN and S_CMP again per close, then S_PUSH. S_CMP holds
// a pending result while the result register waits on rsp_tready. The top
// entry of each stack lives in flip-flops and the rest in a small RAM, so
// each close that leaves entries behind passes S_LOAD to fetch the next top.
// The first sample after reset only primes the history, staying in S_IDLE.
module peak_prominence_detector_core
   import ppd_pkg::*;
#(
   parameter int OPEN_DEPTH  = OPEN_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // req_tdata fields, lowest bit up: sample
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]            req_tdata,
   // rsp_tdata fields, lowest bit up: prominence, sample_echo
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   output logic [((PROM_BITS+SAMPLE_BITS+7)/8)*8-1:0]  rsp_tdata,
   // rsp_tuser fields, lowest bit up: is_trough
   output logic                                        rsp_tuser,
   output logic                                        rsp_tlast,
   input  logic                                        csr_we,
   input  logic                                        csr_addr,
   input  logic [EPS_BITS-1:0]                         csr_wdata
);

   localparam int SB  = SAMPLE_BITS;
   localparam int UW  = ((SB > EPS_BITS) ? SB : EPS_BITS) + 2;
   localparam int AW  = $clog2(OPEN_DEPTH);
   localparam int CW  = $clog2(OPEN_DEPTH + 1);
   localparam int EW  = 3 * SB;
   localparam int RW  = ((PROM_BITS + SB + 7) / 8) * 8;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DX   = 4'd1;
   localparam logic [3:0] S_RISE = 4'd2;
   localparam logic [3:0] S_FALL = 4'd3;
   localparam logic [3:0] S_DEC  = 4'd4;
   localparam logic [3:0] S_CMP  = 4'd5;
   localparam logic [3:0] S_PL   = 4'd6;
   localparam logic [3:0] S_MRG  = 4'd7;
   localparam logic [3:0] S_PR   = 4'd8;
   localparam logic [3:0] S_MIN  = 4'd9;
   localparam logic [3:0] S_LOAD = 4'd10;
   localparam logic [3:0] S_PUSH = 4'd11;
   localparam logic [3:0] S_FIN  = 4'd12;

   logic [3:0]              state_ff;
   logic [EPS_BITS-1:0]     eps_ff;
   logic [FMT_BITS-1:0]     fmt_ff;

   logic signed [SB-1:0]    x_ff;
   logic signed [SB-1:0]    p_ff;
   logic signed [UW-1:0]    d_ff;
   logic                    rise_ff;
   logic [1:0]              dir_ff;
   logic [1:0]              prevdir_ff;
   logic [1:0]              warm_ff;
   logic signed [SB-1:0]    lastpk_ff;
   logic                    havepk_ff;
   logic signed [SB-1:0]    lastvl_ff;
   logic                    havevl_ff;
   logic                    tsel_ff;       // 1: working on the trough stack

   logic [CW-1:0]           cnt_t_ff;
   logic [CW-1:0]           cnt_p_ff;
   logic signed [SB-1:0]    top_t_v_ff, top_t_b_ff, top_t_r_ff;
   logic signed [SB-1:0]    top_p_v_ff, top_p_b_ff, top_p_r_ff;

   logic signed [UW-1:0]    pl_ff;
   logic signed [UW-1:0]    pr_ff;
   logic signed [SB-1:0]    rm_ff;         // merged right extreme, also the cascade accumulator
   logic                    acc_ok_ff;
   logic [PROM_BITS-1:0]    prom_ff;
   logic                    pend_ff;       // a closed entry waits for its tlast decision

   logic                    rsp_valid_ff;
   logic [PROM_BITS-1:0]    rsp_prom_ff;
   logic signed [SB-1:0]    rsp_echo_ff;
   logic                    rsp_trough_ff;
   logic                    rsp_last_ff;

   // shared arithmetic unit
   logic signed [UW-1:0]    alu_a, alu_b, alu_res;
   logic                    alu_sub, alu_neg, alu_zero;

   logic [CW-1:0]           sel_cnt;
   logic signed [SB-1:0]    sel_v, sel_b, sel_r;
   logic [CW-1:0]           rd_idx, wr_idx;
   logic [AW-1:0]           rd_addr, wr_addr;
   logic [EW-1:0]           wr_data, rd_data_t, rd_data_p;
   logic                    wr_en_t, wr_en_p;
   logic                    out_busy, cont;
   logic signed [SB-1:0]    sample_in;
   logic [1:0]              dir_in;
   logic signed [SB-1:0]    left_in;

   assign sample_in  = req_tdata[SB-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign out_busy   = rsp_valid_ff && !rsp_tready;

   assign sel_cnt = tsel_ff ? cnt_t_ff   : cnt_p_ff;
   assign sel_v   = tsel_ff ? top_t_v_ff : top_p_v_ff;
   assign sel_b   = tsel_ff ? top_t_b_ff : top_p_b_ff;
   assign sel_r   = tsel_ff ? top_t_r_ff : top_p_r_ff;

   assign cont    = (sel_cnt != '0) && alu_neg;
   assign dir_in  = rise_ff ? DIR_RISE : (alu_neg ? DIR_FALL : DIR_FLAT);
   assign left_in = tsel_ff ? (havepk_ff ? lastpk_ff : p_ff) : (havevl_ff ? lastvl_ff : p_ff);

   // operand select for the shared unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b1;
      unique case (state_ff)
         S_DX: begin
            alu_a = UW'(x_ff);
            alu_b = UW'(p_ff);
         end
         S_RISE: begin
            alu_a = d_ff;
            alu_b = signed'(UW'(eps_ff));
         end
         S_FALL: begin
            alu_a   = d_ff;
            alu_b   = signed'(UW'(eps_ff));
            alu_sub = 1'b0;
         end
         S_CMP: begin
            alu_a = tsel_ff ? UW'(p_ff) : UW'(sel_v);
            alu_b = tsel_ff ? UW'(sel_v) : UW'(p_ff);
         end
         S_PL: begin
            alu_a = tsel_ff ? UW'(sel_b) : UW'(sel_v);
            alu_b = tsel_ff ? UW'(sel_v) : UW'(sel_b);
         end
         S_MRG: begin
            alu_a = tsel_ff ? UW'(sel_r) : UW'(rm_ff);
            alu_b = tsel_ff ? UW'(rm_ff) : UW'(sel_r);
         end
         S_PR: begin
            alu_a = tsel_ff ? UW'(rm_ff) : UW'(sel_v);
            alu_b = tsel_ff ? UW'(sel_v) : UW'(rm_ff);
         end
         S_MIN: begin
            alu_a = pl_ff;
            alu_b = pr_ff;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   ppd_alu #(.WIDTH(UW)) u_alu (
      .a    (alu_a),
      .b    (alu_b),
      .sub  (alu_sub),
      .res  (alu_res),
      .neg  (alu_neg),
      .zero (alu_zero)
   );

   // stack bodies below the cached tops
   assign rd_idx  = sel_cnt - CW'(2);
   assign wr_idx  = sel_cnt - CW'(1);
   assign rd_addr = rd_idx[AW-1:0];
   assign wr_addr = wr_idx[AW-1:0];
   assign wr_data = {sel_v, sel_b, sel_r};
   assign wr_en_t = (state_ff == S_PUSH) && tsel_ff && (sel_cnt != '0)
                    && (sel_cnt < CW'(OPEN_DEPTH));
   assign wr_en_p = (state_ff == S_PUSH) && !tsel_ff && (sel_cnt != '0)
                    && (sel_cnt < CW'(OPEN_DEPTH));

   ppd_ram #(.WIDTH(EW), .DEPTH(OPEN_DEPTH)) u_trough_ram (
      .clock   (clock),
      .wr_en   (wr_en_t),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data_t)
   );

   ppd_ram #(.WIDTH(EW), .DEPTH(OPEN_DEPTH)) u_peak_ram (
      .clock   (clock),
      .wr_en   (wr_en_p),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         eps_ff       <= '0;
         fmt_ff       <= FMT_UINT16;
         warm_ff      <= 2'd0;
         prevdir_ff   <= DIR_FLAT;
         havepk_ff    <= 1'b0;
         havevl_ff    <= 1'b0;
         cnt_t_ff     <= '0;
         cnt_p_ff     <= '0;
         pend_ff      <= 1'b0;
         acc_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_EPS: eps_ff <= csr_wdata;
               CSR_FMT: fmt_ff <= csr_wdata[FMT_BITS-1:0];
               default: eps_ff <= eps_ff;
            endcase
         end

         // drop the result once taken
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  x_ff <= sample_in;
                  if (warm_ff == 2'd0) begin
                     p_ff       <= sample_in;
                     prevdir_ff <= DIR_FLAT;
                     warm_ff    <= 2'd1;
                  end else begin
                     state_ff <= S_DX;
                  end
               end
            end
            S_DX: begin
               d_ff     <= alu_res;
               state_ff <= S_RISE;
            end
            S_RISE: begin
               rise_ff  <= !alu_neg && !alu_zero;
               state_ff <= S_FALL;
            end
            S_FALL: begin
               dir_ff   <= dir_in;
               state_ff <= S_DEC;
            end
            S_DEC: begin
               acc_ok_ff <= 1'b0;
               if (warm_ff == 2'd1) begin
                  warm_ff  <= 2'd2;
                  state_ff <= S_FIN;
               end else if (prevdir_ff == DIR_FALL && dir_ff == DIR_RISE) begin
                  tsel_ff  <= 1'b1;
                  state_ff <= S_CMP;
               end else if (prevdir_ff == DIR_RISE && dir_ff == DIR_FALL) begin
                  tsel_ff  <= 1'b0;
                  state_ff <= S_CMP;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_CMP: begin
               // hold until the result register frees up
               if (!(pend_ff && out_busy)) begin
                  if (pend_ff) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_prom_ff   <= prom_ff;
                     rsp_echo_ff   <= x_ff;
                     rsp_trough_ff <= tsel_ff;
                     rsp_last_ff   <= !cont;
                     pend_ff       <= 1'b0;
                  end
                  state_ff <= cont ? S_PL : S_PUSH;
               end
            end
            S_PL: begin
               pl_ff    <= alu_res;
               state_ff <= S_MRG;
            end
            S_MRG: begin
               rm_ff    <= (acc_ok_ff && alu_neg) ? rm_ff : sel_r;
               state_ff <= S_PR;
            end
            S_PR: begin
               pr_ff    <= alu_res;
               state_ff <= S_MIN;
            end
            S_MIN: begin
               prom_ff   <= saturate(SAT_BITS'(alu_neg ? pl_ff : pr_ff), fmt_ff);
               pend_ff   <= 1'b1;
               acc_ok_ff <= 1'b1;
               if (tsel_ff) cnt_t_ff <= cnt_t_ff - CW'(1);
               else         cnt_p_ff <= cnt_p_ff - CW'(1);
               state_ff <= (sel_cnt > CW'(1)) ? S_LOAD : S_CMP;
            end
            S_LOAD: begin
               if (tsel_ff) begin
                  {top_t_v_ff, top_t_b_ff, top_t_r_ff} <= rd_data_t;
               end else begin
                  {top_p_v_ff, top_p_b_ff, top_p_r_ff} <= rd_data_p;
               end
               state_ff <= S_CMP;
            end
            S_PUSH: begin
               if (sel_cnt < CW'(OPEN_DEPTH)) begin
                  if (tsel_ff) begin
                     top_t_v_ff <= p_ff;
                     top_t_b_ff <= left_in;
                     top_t_r_ff <= x_ff;
                     cnt_t_ff   <= cnt_t_ff + CW'(1);
                  end else begin
                     top_p_v_ff <= p_ff;
                     top_p_b_ff <= left_in;
                     top_p_r_ff <= x_ff;
                     cnt_p_ff   <= cnt_p_ff + CW'(1);
                  end
               end
               if (tsel_ff) begin
                  havevl_ff <= 1'b1;
                  lastvl_ff <= p_ff;
                  havepk_ff <= 1'b0;
               end else begin
                  havepk_ff <= 1'b1;
                  lastpk_ff <= p_ff;
                  havevl_ff <= 1'b0;
               end
               state_ff <= S_FIN;
            end
            S_FIN: begin
               // advance the run extremes of both tops
               if (cnt_p_ff != '0 && x_ff < top_p_r_ff) top_p_r_ff <= x_ff;
               if (cnt_t_ff != '0 && x_ff > top_t_r_ff) top_t_r_ff <= x_ff;
               prevdir_ff <= dir_ff;
               p_ff       <= x_ff;
               state_ff   <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RW'({rsp_echo_ff, rsp_prom_ff});
   assign rsp_tuser  = rsp_trough_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hw/rtl/ppd_checker.sv */
module ppd_checker
   import ppd_pkg::*;
#(
   parameter int OPEN_DEPTH  = OPEN_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   input  logic                                        req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]            req_tdata,
   input  logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   input  logic [((PROM_BITS+SAMPLE_BITS+7)/8)*8-1:0]  rsp_tdata,
   input  logic                                        rsp_tuser,
   input  logic                                        rsp_tlast,
   input  logic                                        csr_we,
   input  logic                                        csr_addr,
   input  logic [EPS_BITS-1:0]                         csr_wdata
);

   localparam int DEPTH_CHK = OPEN_DEPTH;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // saturated prominence stays within int32 low and uint32 high
   a_prom_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[PROM_BITS-1] |-> rsp_tdata[PROM_BITS-2])
      else $error("prominence outside saturation range");

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a run that is not finished keeps the input side closed
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast && (DEPTH_CHK > 0) |=> !req_tready)
      else $error("input ready in the middle of a run");

endmodule

bind peak_prominence_detector_core ppd_checker #(
   .OPEN_DEPTH  (OPEN_DEPTH),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_ppd_checker (.*);
